// File: rtl/core/opi_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package opi_pkg;

  // field and register widths
  localparam int unsigned LIN_W      = 16;
  localparam int unsigned ANG_W      = 24;
  localparam int unsigned PERIOD_W   = 16;
  localparam int unsigned FC_W       = 24;
  localparam int unsigned THR_W      = 24;
  localparam int unsigned HEAD_W     = 24;
  localparam int unsigned TRAV_W     = 32;
  localparam int unsigned CARRY_W    = 21;

  localparam int unsigned DISTANCE_WIDTH_DEF = 32;

  // tick divisor and the widths of the sums around it
  localparam int unsigned TICK_DIVISOR = 1000000;
  localparam int unsigned DIV_W        = 20;  // holds the tick divisor and its remainders
  localparam int unsigned HDVS_W       = 24;  // divisor width of the shared heading divider
  localparam int unsigned DSUM_W       = 34;
  localparam int unsigned DMAG_W       = 33;
  localparam int unsigned HSUM_W       = 41;
  localparam int unsigned HMAG_W       = 40;
  localparam int unsigned DQ_W         = 14;
  localparam int unsigned HQ_W         = 21;
  localparam int unsigned H_W          = 26;  // heading plus delta, signed
  localparam int unsigned HABS_W       = 25;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_US   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_FULL_CIRCLE = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_TURN_THR    = CFG_IDX_W'(2);

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(1000);
  localparam logic [FC_W-1:0]     FC_RESET     = FC_W'(36000);
  localparam logic [THR_W-1:0]    THR_RESET    = THR_W'(25);

endpackage
`default_nettype wire

// File: rtl/core/opi_smul.sv
`timescale 1ns / 1ps
`default_nettype none
module opi_smul #(
  parameter int unsigned MC_W = 24,
  parameter int unsigned P_W  = 41
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic signed [MC_W-1:0]        mcand_i,
  input  wire logic [opi_pkg::PERIOD_W-1:0]  mplier_i,
  input  wire logic signed [P_W-1:0]         addend_i,
  output logic                               busy_o,
  output logic signed [P_W-1:0]              prod_o
);
  import opi_pkg::*;

  localparam int unsigned CW = $clog2(PERIOD_W + 1);

  logic signed [P_W-1:0]  acc_q;
  logic signed [P_W-1:0]  mc_q;
  logic [PERIOD_W-1:0]    mp_q;
  logic [CW-1:0]          cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= CW'(PERIOD_W);
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - CW'(1);
    end
  end

  // one multiplier bit a cycle, lsb first, the addend preloaded
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= addend_i;
      mc_q  <= P_W'(mcand_i);
      mp_q  <= mplier_i;
    end else if (cnt_q != '0) begin
      if (mp_q[0]) begin
        acc_q <= acc_q + mc_q;
      end
      mc_q <= mc_q <<< 1;
      mp_q <= mp_q >> 1;
    end
  end

  assign busy_o = (cnt_q != '0);
  assign prod_o = acc_q;

endmodule
`default_nettype wire

// File: rtl/core/opi_sdiv.sv
`timescale 1ns / 1ps
`default_nettype none
module opi_sdiv #(
  parameter int unsigned N = 40,
  parameter int unsigned M = 24,
  localparam int unsigned CW = $clog2(N + 1)
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic [CW-1:0] iter_i,
  input  wire logic [N-1:0]  dividend_i,  // msb aligned, iter_i bits in use
  input  wire logic [M-1:0]  divisor_i,
  output logic               busy_o,
  output logic [N-1:0]       quot_o,
  output logic [M-1:0]       rem_o
);
  import opi_pkg::*;

  logic [N-1:0]  dq_q;
  logic [M-1:0]  rem_q;
  logic [M-1:0]  dvs_q;
  logic [CW-1:0] cnt_q;
  logic [M:0]    trial;
  logic          ge;

  // restoring step, one quotient bit a cycle
  assign trial = {rem_q, dq_q[N-1]};
  assign ge    = (trial >= {1'b0, dvs_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= iter_i;
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dq_q  <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (cnt_q != '0) begin
      rem_q <= ge ? M'(trial - {1'b0, dvs_q}) : trial[M-1:0];
      dq_q  <= {dq_q[N-2:0], ge};
    end
  end

  assign busy_o = (cnt_q != '0);
  assign quot_o = dq_q;
  assign rem_o  = rem_q;

endmodule
`default_nettype wire

// File: rtl/core/odometry_pose_integrator_top.sv
`timescale 1ns / 1ps
`default_nettype none
// channel   dir  handshake                 payload
// in        in   in_valid_i / in_ready_o   linear_speed_i, angular_speed_i
// out       out  out_valid_o / out_ready_i heading_o, travelled_o
// cfg       in   cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// a tick runs from request to result through 16 multiply steps, 40 steps of the
// heading division by the tick divisor and 25 steps of the heading wrap division,
// all in bit-serial units, the two heading divisions sharing one divider, plus
// the sequencing states. a zero full_circle skips the wrap division.
// one tick is worked at a time; the next request is taken while a result still waits
// in the output register, and a tick stalls at the end until that register is free.
// rst_ni clears accumulators and carries and loads the register defaults.
// cfg_ready_o is always high.
module odometry_pose_integrator_top #(
  parameter int unsigned DISTANCE_WIDTH = opi_pkg::DISTANCE_WIDTH_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire logic signed [opi_pkg::LIN_W-1:0]  linear_speed_i,
  input  wire logic signed [opi_pkg::ANG_W-1:0]  angular_speed_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic [opi_pkg::HEAD_W-1:0]             heading_o,
  output logic signed [opi_pkg::TRAV_W-1:0]      travelled_o,
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [opi_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [opi_pkg::CFG_DATA_W-1:0]    cfg_data_i
);
  import opi_pkg::*;

  localparam int unsigned HCW = $clog2(HMAG_W + 1);
  localparam int unsigned DCW = $clog2(DMAG_W + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_DIV,
    S_FIX,
    S_MOD,
    S_WRAP,
    S_OUT
  } state_e;

  state_e state_q;

  logic [PERIOD_W-1:0] period_q;
  logic [FC_W-1:0]     fc_q;
  logic [THR_W-1:0]    thr_q;

  logic signed [CARRY_W-1:0] dcarry_q;
  logic signed [CARRY_W-1:0] hcarry_q;
  logic [HEAD_W-1:0]         hacc_q;
  logic [DISTANCE_WIDTH-1:0] dacc_q;

  logic                  hen_q;
  logic                  dneg_q;
  logic                  hneg_q;
  logic signed [H_W-1:0] h_q;
  logic [HEAD_W-1:0]     hnew_q;

  logic                     out_valid_q;
  logic [HEAD_W-1:0]        out_head_q;
  logic signed [TRAV_W-1:0] out_trav_q;

  logic              in_acc;
  logic [ANG_W-1:0]  w_abs;
  logic              hen;

  logic                     dmul_busy;
  logic                     hmul_busy;
  logic signed [DSUM_W-1:0] dprod;
  logic signed [HSUM_W-1:0] hprod;

  logic               div_go;
  logic               wrap_go;
  logic [DMAG_W-1:0]  dmag;
  logic [HMAG_W-1:0]  hmag;
  logic               ddiv_busy;
  logic               hdiv_busy;
  logic [DMAG_W-1:0]  dquot;
  logic [DIV_W-1:0]   drem;
  logic [HMAG_W-1:0]  hquot;
  logic [HDVS_W-1:0]  hrem;
  logic               hdiv_start;
  logic [HCW-1:0]     hdiv_iter;
  logic [HMAG_W-1:0]  hdiv_dividend;
  logic [HDVS_W-1:0]  hdiv_divisor;

  logic [DISTANCE_WIDTH-1:0] dq_ext;
  logic [H_W-1:0]            hq_ext;
  logic [H_W-1:0]            hacc_ext;
  logic signed [H_W-1:0]     hsum;
  logic [HABS_W-1:0]         habs;
  logic [HEAD_W-1:0]         wrapped;
  logic                      out_load;

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  // below the noise threshold the heading stands still
  assign w_abs = angular_speed_i[ANG_W-1] ? (~angular_speed_i + ANG_W'(1)) : angular_speed_i;
  assign hen   = (w_abs >= thr_q);

  opi_smul #(
    .MC_W (LIN_W),
    .P_W  (DSUM_W)
  ) u_dmul (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (in_acc),
    .mcand_i  (linear_speed_i),
    .mplier_i (period_q),
    .addend_i (DSUM_W'(dcarry_q)),
    .busy_o   (dmul_busy),
    .prod_o   (dprod)
  );

  opi_smul #(
    .MC_W (ANG_W),
    .P_W  (HSUM_W)
  ) u_hmul (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (in_acc),
    .mcand_i  (angular_speed_i),
    .mplier_i (period_q),
    .addend_i (HSUM_W'(hcarry_q)),
    .busy_o   (hmul_busy),
    .prod_o   (hprod)
  );

  assign div_go  = (state_q == S_MUL) && !dmul_busy && !hmul_busy;
  assign wrap_go = (state_q == S_MOD) && (fc_q != '0);

  assign dmag = dprod[DSUM_W-1] ? DMAG_W'(-dprod) : DMAG_W'(dprod);
  assign hmag = hprod[HSUM_W-1] ? HMAG_W'(-hprod) : HMAG_W'(hprod);

  opi_sdiv #(
    .N (DMAG_W),
    .M (DIV_W)
  ) u_ddiv (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_go),
    .iter_i     (DCW'(DMAG_W)),
    .dividend_i (dmag),
    .divisor_i  (DIV_W'(TICK_DIVISOR)),
    .busy_o     (ddiv_busy),
    .quot_o     (dquot),
    .rem_o      (drem)
  );

  // heading divider: first by the tick divisor, then the wrap by full_circle
  assign habs          = h_q[H_W-1] ? HABS_W'(-h_q) : HABS_W'(h_q);
  assign hdiv_start    = div_go || wrap_go;
  assign hdiv_iter     = wrap_go ? HCW'(HABS_W) : HCW'(HMAG_W);
  assign hdiv_dividend = wrap_go ? {habs, {(HMAG_W - HABS_W){1'b0}}} : hmag;
  assign hdiv_divisor  = wrap_go ? HDVS_W'(fc_q) : HDVS_W'(TICK_DIVISOR);

  opi_sdiv #(
    .N (HMAG_W),
    .M (HDVS_W)
  ) u_hdiv (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (hdiv_start),
    .iter_i     (hdiv_iter),
    .dividend_i (hdiv_dividend),
    .divisor_i  (hdiv_divisor),
    .busy_o     (hdiv_busy),
    .quot_o     (hquot),
    .rem_o      (hrem)
  );

  assign dq_ext   = DISTANCE_WIDTH'(dquot[DQ_W-1:0]);
  assign hq_ext   = H_W'(hquot[HQ_W-1:0]);
  assign hacc_ext = H_W'(hacc_q);
  assign hsum     = !hen_q ? signed'(hacc_ext) :
                    hneg_q ? signed'(hacc_ext - hq_ext) : signed'(hacc_ext + hq_ext);

  // truncated remainder of a negative sum folds back into the circle
  assign wrapped = (h_q[H_W-1] && (hrem != '0)) ? (fc_q - hrem) : hrem;

  assign out_load = (state_q == S_OUT) && (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      period_q    <= PERIOD_RESET;
      fc_q        <= FC_RESET;
      thr_q       <= THR_RESET;
      dcarry_q    <= '0;
      hcarry_q    <= '0;
      hacc_q      <= '0;
      dacc_q      <= '0;
      hen_q       <= 1'b0;
      dneg_q      <= 1'b0;
      hneg_q      <= 1'b0;
      h_q         <= '0;
      hnew_q      <= '0;
      out_valid_q <= 1'b0;
      out_head_q  <= '0;
      out_trav_q  <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_PERIOD_US:   period_q <= cfg_data_i[PERIOD_W-1:0];
          CFG_FULL_CIRCLE: fc_q     <= cfg_data_i[FC_W-1:0];
          CFG_TURN_THR:    thr_q    <= cfg_data_i[THR_W-1:0];
          default: ;
        endcase
      end

      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            hen_q   <= hen;
            state_q <= S_MUL;
          end
        end
        S_MUL: begin
          if (div_go) begin
            dneg_q  <= dprod[DSUM_W-1];
            hneg_q  <= hprod[HSUM_W-1];
            state_q <= S_DIV;
          end
        end
        S_DIV: begin
          if (!ddiv_busy && !hdiv_busy) begin
            state_q <= S_FIX;
          end
        end
        S_FIX: begin
          dacc_q   <= dneg_q ? (dacc_q - dq_ext) : (dacc_q + dq_ext);
          dcarry_q <= dneg_q ? -signed'({1'b0, drem}) : signed'({1'b0, drem});
          if (hen_q) begin
            hcarry_q <= hneg_q ? -signed'({1'b0, hrem[DIV_W-1:0]})
                               : signed'({1'b0, hrem[DIV_W-1:0]});
          end
          h_q     <= hsum;
          state_q <= S_MOD;
        end
        S_MOD: begin
          if (wrap_go) begin
            state_q <= S_WRAP;
          end else begin
            hnew_q  <= h_q[HEAD_W-1:0];
            state_q <= S_OUT;
          end
        end
        S_WRAP: begin
          if (!hdiv_busy) begin
            hnew_q  <= wrapped;
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_load) begin
            hacc_q     <= hnew_q;
            out_head_q <= hnew_q;
            out_trav_q <= TRAV_W'(signed'(dacc_q));
            state_q    <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign heading_o   = out_head_q;
  assign travelled_o = out_trav_q;

endmodule
`default_nettype wire

// File: rtl/core/opi_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module opi_checker (
  input wire logic                              clk_i,
  input wire logic                              rst_ni,
  input wire logic                              in_valid_i,
  input wire logic                              in_ready_o,
  input wire logic signed [opi_pkg::LIN_W-1:0]  linear_speed_i,
  input wire logic signed [opi_pkg::ANG_W-1:0]  angular_speed_i,
  input wire logic                              out_valid_o,
  input wire logic                              out_ready_i,
  input wire logic [opi_pkg::HEAD_W-1:0]        heading_o,
  input wire logic signed [opi_pkg::TRAV_W-1:0] travelled_o,
  input wire logic                              cfg_valid_i,
  input wire logic                              cfg_ready_o,
  input wire logic [opi_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input wire logic [opi_pkg::CFG_DATA_W-1:0]    cfg_data_i
);
  import opi_pkg::*;

  logic [FC_W-1:0] fc_q;
  logic [1:0]      pend_q;
  logic            in_acc;
  logic            out_acc;
  logic            in_seen;

  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;
  // keeps the input payload in view of the checker
  assign in_seen = in_acc && ((linear_speed_i != '0) || (angular_speed_i != '0));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fc_q   <= FC_RESET;
      pend_q <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_o && (cfg_index_i == CFG_FULL_CIRCLE)) begin
        fc_q <= cfg_data_i[FC_W-1:0];
      end
      pend_q <= pend_q + 2'(in_acc || in_seen) - 2'(out_acc);
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(heading_o) && $stable(travelled_o))
    else $error("result changed while stalled");

  a_heading_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (fc_q != '0) |-> (heading_o < fc_q))
    else $error("heading outside the circle");

  a_no_extra_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (pend_q != 2'd0))
    else $error("result without a request");

  a_one_in_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> (pend_q <= 2'd1))
    else $error("request taken while another is in work");

  a_last_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && (pend_q == 2'd1) |=> !out_valid_o)
    else $error("result repeated");

endmodule

bind odometry_pose_integrator_top opi_checker u_opi_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_ready_o      (in_ready_o),
  .linear_speed_i  (linear_speed_i),
  .angular_speed_i (angular_speed_i),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .heading_o       (heading_o),
  .travelled_o     (travelled_o),
  .cfg_valid_i     (cfg_valid_i),
  .cfg_ready_o     (cfg_ready_o),
  .cfg_index_i     (cfg_index_i),
  .cfg_data_i      (cfg_data_i)
);
`default_nettype wire

// File: test/tb_odometry_pose_integrator_top.sv
`timescale 1ns / 1ps
module tb_odometry_pose_integrator_top;
  import opi_pkg::*;

  localparam int unsigned RANDOM_TICKS  = 700;
  localparam int unsigned QUIET_LIMIT   = 4000;
  localparam int unsigned SETTLE_CYCLES = 200;
  localparam longint      TICK_DIV      = TICK_DIVISOR;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = CFG_IDX_W'(3);

  localparam logic signed [LIN_W-1:0] LIN_MAX = 16'sh7FFF;
  localparam logic signed [LIN_W-1:0] LIN_MIN = 16'sh8000;
  localparam logic signed [ANG_W-1:0] ANG_MAX = 24'sh7FFFFF;
  localparam logic signed [ANG_W-1:0] ANG_MIN = 24'sh800000;
  localparam logic [CFG_DATA_W-1:0]   DATA_MAX = 24'hFFFFFF;

  typedef struct packed {
    logic [HEAD_W-1:0]        heading;
    logic signed [TRAV_W-1:0] travelled;
  } pose_t;

  typedef enum logic {ROW_TICK, ROW_CFG} row_kind_e;

  typedef struct {
    row_kind_e                kind;
    logic signed [LIN_W-1:0]  lin;
    logic signed [ANG_W-1:0]  ang;
    logic [CFG_IDX_W-1:0]     idx;
    logic [CFG_DATA_W-1:0]    data;
    bit                       typed;
    pose_t                    want;
  } step_row_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    in_valid_i = 1'b0;
  logic                    in_ready_o;
  logic signed [LIN_W-1:0] linear_speed_i = '0;
  logic signed [ANG_W-1:0] angular_speed_i = '0;
  logic                    out_valid_o;
  logic                    out_ready_i = 1'b0;
  logic [HEAD_W-1:0]       heading_o;
  logic signed [TRAV_W-1:0] travelled_o;
  logic                    cfg_valid_i = 1'b0;
  logic                    cfg_ready_o;
  logic [CFG_IDX_W-1:0]    cfg_index_i = '0;
  logic [CFG_DATA_W-1:0]   cfg_data_i = '0;

  // predictor copy of the registers and the integration state
  logic [PERIOD_W-1:0]     pred_period = PERIOD_RESET;
  logic [FC_W-1:0]         pred_circle = FC_RESET;
  logic [THR_W-1:0]        pred_turn_thr = THR_RESET;
  longint                  dist_rem = 0;
  longint                  head_rem = 0;
  logic [HEAD_W-1:0]       head_acc = '0;
  logic [TRAV_W-1:0]       dist_acc = '0;

  pose_t                   pose_q[$];
  step_row_t               plan[$];
  int unsigned             mismatches = 0;
  int unsigned             quiet_cycles = 0;
  int unsigned             stall_left = 0;
  bit                      steady_phase = 1'b0;

  odometry_pose_integrator_top u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .linear_speed_i  (linear_speed_i),
    .angular_speed_i (angular_speed_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .heading_o       (heading_o),
    .travelled_o     (travelled_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic report_mismatch(input string what);
    $display("%0t mismatch: %s", $time, what);
    mismatches++;
  endtask

  // one tick of dead reckoning; remainders keep the sign of the dividend
  task automatic integrate_tick(input logic signed [LIN_W-1:0] lin,
                                input logic signed [ANG_W-1:0] ang,
                                output pose_t pose);
    longint sum;
    longint dd;
    longint dh;
    longint h;
    longint w;
    dh = 0;
    w = longint'(ang);
    sum = longint'(lin) * longint'(pred_period) + dist_rem;
    dist_rem = sum % TICK_DIV;
    dd = sum / TICK_DIV;
    if (((w < 0) ? -w : w) >= longint'(pred_turn_thr)) begin
      sum = w * longint'(pred_period) + head_rem;
      head_rem = sum % TICK_DIV;
      dh = sum / TICK_DIV;
    end
    h = longint'(head_acc) + dh;
    if (pred_circle != '0) begin
      h = h % longint'(pred_circle);
      if (h < 0) h = h + longint'(pred_circle);
    end
    head_acc = h[HEAD_W-1:0];
    dist_acc = dist_acc + dd[TRAV_W-1:0];
    pose.heading = head_acc;
    pose.travelled = dist_acc;
  endtask

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (steady_phase || r < 10) return 0;
    if (r < 17) return $urandom_range(1, 3);
    if (r < 19) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic step_row_t tick_row(input logic signed [LIN_W-1:0] lin,
                                         input logic signed [ANG_W-1:0] ang);
    step_row_t r;
    r.kind = ROW_TICK;
    r.lin = lin;
    r.ang = ang;
    r.idx = '0;
    r.data = '0;
    r.typed = 1'b0;
    r.want = '0;
    return r;
  endfunction

  function automatic step_row_t typed_row(input logic signed [LIN_W-1:0] lin,
                                          input logic signed [ANG_W-1:0] ang,
                                          input logic [HEAD_W-1:0] head,
                                          input logic signed [TRAV_W-1:0] trav);
    step_row_t r;
    r = tick_row(lin, ang);
    r.typed = 1'b1;
    r.want.heading = head;
    r.want.travelled = trav;
    return r;
  endfunction

  function automatic step_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [CFG_DATA_W-1:0] data);
    step_row_t r;
    r = tick_row('0, '0);
    r.kind = ROW_CFG;
    r.idx = idx;
    r.data = data;
    return r;
  endfunction

  task automatic send_tick(input logic signed [LIN_W-1:0] lin,
                           input logic signed [ANG_W-1:0] ang,
                           input bit typed, input pose_t typed_pose);
    pose_t p;
    int unsigned gap;
    if (cfg_valid_i) cfg_valid_i <= 1'b0;
    in_valid_i <= 1'b1;
    linear_speed_i <= lin;
    angular_speed_i <= ang;
    // hold the request until it is taken
    do @(posedge clk_i); while (!in_ready_o);
    integrate_tick(lin, ang, p);
    pose_q.push_back(typed ? typed_pose : p);
    gap = pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic wait_results_done();
    if (in_valid_i) in_valid_i <= 1'b0;
    while (pose_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_PERIOD_US:   pred_period = data[PERIOD_W-1:0];
      CFG_FULL_CIRCLE: pred_circle = data[FC_W-1:0];
      CFG_TURN_THR:    pred_turn_thr = data[THR_W-1:0];
      default: ;
    endcase
  endtask

  always @(posedge clk_i) begin : rx_pace
    int unsigned hold;
    hold = ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
    if (stall_left != 0) begin
      out_ready_i <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (hold != 0) begin
      out_ready_i <= 1'b0;
      stall_left <= hold - 1;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin : pose_check
    pose_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pose_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result heading %0d travelled %0d",
                                  heading_o, travelled_o));
      end else begin
        want = pose_q.pop_front();
        if (heading_o !== want.heading)
          report_mismatch($sformatf("heading %0d, expected %0d", heading_o, want.heading));
        if (travelled_o !== want.travelled)
          report_mismatch($sformatf("travelled %0d, expected %0d", travelled_o, want.travelled));
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("tb_odometry_pose_integrator_top: done, errors");
      $finish;
    end
  end

  initial begin
    int unsigned ticks_done;
    int unsigned n_items;
    int unsigned k;
    logic signed [LIN_W-1:0] lin;
    logic signed [ANG_W-1:0] ang;
    logic [CFG_DATA_W-1:0] val;
    longint t;

    ticks_done = 0;
    plan.push_back(typed_row('0, '0, 24'd0, 32'sd0));
    plan.push_back(typed_row(16'sd1000, 24'sd1000, 24'd1, 32'sd1));
    plan.push_back(typed_row(LIN_MAX, ANG_MAX, 24'd8389, 32'sd33));
    plan.push_back(typed_row(LIN_MIN, ANG_MIN, 24'd1, 32'sd1));
    // just under the turn threshold: heading and its remainder held
    plan.push_back(typed_row('0, 24'sd24, 24'd1, 32'sd1));
    plan.push_back(tick_row('0, -24'sd24));
    plan.push_back(tick_row(16'sd5, -24'sd25));
    // zero period leaves only the carries to divide
    plan.push_back(cfg_row(CFG_PERIOD_US, '0));
    plan.push_back(tick_row(16'sd12345, 24'sd4000000));
    plan.push_back(cfg_row(CFG_PERIOD_US, 24'd65535));
    plan.push_back(tick_row(LIN_MAX, ANG_MAX));
    plan.push_back(tick_row(LIN_MIN, ANG_MIN));
    // no modulus, heading wraps at its own width
    plan.push_back(cfg_row(CFG_FULL_CIRCLE, '0));
    plan.push_back(tick_row(-16'sd1, ANG_MIN));
    plan.push_back(tick_row(-16'sd1, ANG_MIN));
    // heading now far beyond the new circle
    plan.push_back(cfg_row(CFG_FULL_CIRCLE, 24'd360));
    plan.push_back(tick_row('0, '0));
    plan.push_back(cfg_row(CFG_TURN_THR, '0));
    plan.push_back(tick_row('0, '0));
    plan.push_back(cfg_row(CFG_TURN_THR, DATA_MAX));
    plan.push_back(tick_row(LIN_MIN, ANG_MAX));
    plan.push_back(cfg_row(CFG_UNUSED, DATA_MAX));
    plan.push_back(cfg_row(CFG_FULL_CIRCLE, DATA_MAX));
    plan.push_back(tick_row(16'sd1, -24'sd1));
    plan.push_back(cfg_row(CFG_FULL_CIRCLE, 24'd1));
    plan.push_back(tick_row(LIN_MAX, ANG_MIN));

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        wait_results_done();
        write_reg(plan[i].idx, plan[i].data);
      end else begin
        send_tick(plan[i].lin, plan[i].ang, plan[i].typed, plan[i].want);
      end
    end

    while (ticks_done < RANDOM_TICKS) begin
      wait_results_done();
      steady_phase = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 2) != 0) begin
        case ($urandom_range(0, 9))
          0: val = 24'd1;
          1: val = 24'd65535;
          2: val = '0;
          default: val = CFG_DATA_W'($urandom_range(1, 65535));
        endcase
        write_reg(CFG_PERIOD_US, val);
      end
      if ($urandom_range(0, 2) != 0) begin
        case ($urandom_range(0, 9))
          0: val = '0;
          1: val = 24'd1;
          2: val = DATA_MAX;
          3: val = FC_RESET;
          4, 5, 6: val = CFG_DATA_W'($urandom_range(2, 4000));
          default: val = CFG_DATA_W'($urandom_range(2, 16777215));
        endcase
        write_reg(CFG_FULL_CIRCLE, val);
      end
      if ($urandom_range(0, 2) != 0) begin
        case ($urandom_range(0, 9))
          0: val = '0;
          1: val = DATA_MAX;
          2, 3: val = CFG_DATA_W'($urandom_range(0, 16777215));
          default: val = CFG_DATA_W'($urandom_range(0, 200));
        endcase
        write_reg(CFG_TURN_THR, val);
      end
      if ($urandom_range(0, 9) == 0) write_reg(CFG_UNUSED, CFG_DATA_W'($urandom));

      n_items = $urandom_range(20, 80);
      for (k = 0; k < n_items; k++) begin
        if (k == n_items / 2 && $urandom_range(0, 4) == 0) wait_results_done();
        case ($urandom_range(0, 7))
          0: lin = $urandom_range(0, 1) ? LIN_MAX : LIN_MIN;
          1: lin = LIN_W'($urandom_range(0, 4000)) - LIN_W'(2000);
          default: lin = LIN_W'($urandom);
        endcase
        case ($urandom_range(0, 5))
          0: begin
            // straddle the turn threshold from both sides
            t = longint'(pred_turn_thr) - longint'($urandom_range(0, 1));
            if (t < 0) t = 0;
            if (t > 8388607) t = 8388607;
            if ($urandom_range(0, 1) != 0) t = -t;
            ang = t[ANG_W-1:0];
          end
          1: ang = $urandom_range(0, 1) ? ANG_MAX : ANG_MIN;
          2: ang = ANG_W'($urandom_range(0, 40000)) - ANG_W'(20000);
          default: ang = ANG_W'($urandom);
        endcase
        send_tick(lin, ang, 1'b0, '0);
        ticks_done++;
      end
    end

    wait_results_done();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("tb_odometry_pose_integrator_top: done, clean");
    end else begin
      $display("tb_odometry_pose_integrator_top: done, errors");
    end
    $finish;
  end

endmodule

// File: odometry_pose_integrator_top.f
rtl/core/opi_pkg.sv
rtl/core/opi_smul.sv
rtl/core/opi_sdiv.sv
rtl/core/odometry_pose_integrator_top.sv
rtl/core/opi_checker.sv
test/tb_odometry_pose_integrator_top.sv
